// ===== hw/rtl/ssrl_pkg.sv =====
package ssrl_pkg;

  localparam int unsigned OP_W     = 4;
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned REASON_W = 8;
  localparam int unsigned STATE_W  = 3;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned AGE_W    = 32;
  localparam int unsigned LIM_W    = 24;
  localparam int unsigned MAXR_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned REGIDX_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_START            = 4'd0,
    OP_STOP             = 4'd1,
    OP_TICK             = 4'd2,
    OP_CONFIRM_READY    = 4'd3,
    OP_FAIL_STARTUP     = 4'd4,
    OP_BEGIN_REQUEST    = 4'd5,
    OP_COMPLETE_REQUEST = 4'd6,
    OP_FAIL_REQUEST     = 4'd7,
    OP_FORCE_FATAL      = 4'd8
  } op_e;

  typedef enum logic [STATE_W-1:0] {
    SVC_STOPPED    = 3'd0,
    SVC_STARTING   = 3'd1,
    SVC_READY      = 3'd2,
    SVC_BUSY       = 3'd3,
    SVC_RESTARTING = 3'd4,
    SVC_FATAL      = 3'd5
  } svc_state_e;

  typedef enum logic [KIND_W-1:0] {
    ERR_NONE      = 2'd0,
    ERR_START_TMO = 2'd1,
    ERR_REQ_TMO   = 2'd2,
    ERR_CALLER    = 2'd3
  } err_kind_e;

  typedef enum logic [REGIDX_W-1:0] {
    REG_STARTUP_DELAY    = 3'd0,
    REG_STARTUP_TIMEOUT  = 3'd1,
    REG_REQUEST_TIMEOUT  = 3'd2,
    REG_HEARTBEAT_INTVL  = 3'd3,
    REG_RESTART_WINDOW   = 3'd4,
    REG_MAX_RESTARTS     = 3'd5,
    REG_RESTART_COOLDOWN = 3'd6,
    REG_STUB_MODE        = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [LIM_W-1:0]  startup_delay;
    logic [LIM_W-1:0]  startup_timeout;
    logic [LIM_W-1:0]  request_timeout;
    logic [LIM_W-1:0]  heartbeat_interval;
    logic [LIM_W-1:0]  restart_window;
    logic [MAXR_W-1:0] max_restarts;
    logic [LIM_W-1:0]  restart_cooldown;
    logic              stub_mode;
  } cfg_t;

  typedef struct packed {
    logic gt;
    logic ge;
  } alu_flags_t;

  localparam logic [LIM_W-1:0]  RST_STARTUP_DELAY    = 24'd0;
  localparam logic [LIM_W-1:0]  RST_STARTUP_TIMEOUT  = 24'd10000;
  localparam logic [LIM_W-1:0]  RST_REQUEST_TIMEOUT  = 24'd30000;
  localparam logic [LIM_W-1:0]  RST_HEARTBEAT_INTVL  = 24'd1000;
  localparam logic [LIM_W-1:0]  RST_RESTART_WINDOW   = 24'd60000;
  localparam logic [MAXR_W-1:0] RST_MAX_RESTARTS     = 4'd3;
  localparam logic [LIM_W-1:0]  RST_RESTART_COOLDOWN = 24'd2000;
  localparam logic              RST_STUB_MODE        = 1'b0;

endpackage

// ===== hw/rtl/ssrl_in_if.sv =====
interface ssrl_in_if;
  logic                            valid;
  logic                            ready;
  logic [ssrl_pkg::OP_W-1:0]       op;
  logic [ssrl_pkg::NOW_W-1:0]      now_time;
  logic [ssrl_pkg::REASON_W-1:0]   error_reason;

  modport source (output valid, op, now_time, error_reason, input ready);
  modport sink (input valid, op, now_time, error_reason, output ready);
endinterface

// ===== hw/rtl/ssrl_out_if.sv =====
interface ssrl_out_if;
  logic                            valid;
  logic                            ready;
  logic [ssrl_pkg::STATE_W-1:0]    service_state;
  logic                            request_accepted;
  logic                            pending_request;
  logic [ssrl_pkg::CNT_W-1:0]      restart_total;
  logic [ssrl_pkg::AGE_W-1:0]      heartbeat_age;
  logic [ssrl_pkg::KIND_W-1:0]     error_kind;
  logic [ssrl_pkg::REASON_W-1:0]   last_reason;
  logic                            state_changed;

  modport source (output valid, service_state, request_accepted, pending_request,
                  restart_total, heartbeat_age, error_kind, last_reason, state_changed,
                  input ready);
  modport sink (input valid, service_state, request_accepted, pending_request,
                restart_total, heartbeat_age, error_kind, last_reason, state_changed,
                output ready);
endinterface

// ===== hw/rtl/ssrl_alu.sv =====
module ssrl_alu #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                         sub_i,
  input  logic [TIME_WIDTH-1:0]        a_i,
  input  logic [TIME_WIDTH-1:0]        b_i,
  input  logic [ssrl_pkg::LIM_W-1:0]   lim_i,
  output logic [TIME_WIDTH-1:0]        res_o,
  output ssrl_pkg::alu_flags_t         flags_o
);

  localparam int unsigned CW = (TIME_WIDTH > ssrl_pkg::LIM_W) ? TIME_WIDTH : ssrl_pkg::LIM_W;

  logic [CW-1:0] res_ext;
  logic [CW-1:0] lim_ext;

  // Differences wrap modulo 2^TIME_WIDTH
  assign res_o   = sub_i ? (a_i - b_i) : (a_i + b_i);
  assign res_ext = CW'(res_o);
  assign lim_ext = CW'(lim_i);

  assign flags_o.gt = (res_ext > lim_ext);
  assign flags_o.ge = (res_ext >= lim_ext);

endmodule

// ===== hw/rtl/ssrl_ctrl.sv =====
module ssrl_ctrl #(
  parameter int unsigned HISTORY_DEPTH = 8,
  parameter int unsigned TIME_WIDTH    = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ssrl_pkg::cfg_t   cfg_i,
  ssrl_in_if.sink          in_i,
  ssrl_out_if.source       out_o
);

  localparam int unsigned TW   = TIME_WIDTH;
  localparam int unsigned IDXW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CMPW = (CNTW > ssrl_pkg::MAXR_W) ? CNTW : ssrl_pkg::MAXR_W;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(HISTORY_DEPTH - 1);

  typedef enum logic [7:0] {
    SQ_IDLE     = 8'b0000_0001,
    SQ_DISP     = 8'b0000_0010,
    SQ_TICK_CHK = 8'b0000_0100,
    SQ_TICK_DUE = 8'b0000_1000,
    SQ_SCAN     = 8'b0001_0000,
    SQ_COMMIT   = 8'b0010_0000,
    SQ_START    = 8'b0100_0000,
    SQ_DONE     = 8'b1000_0000
  } seq_e;

  seq_e                             seq_q;
  logic [ssrl_pkg::OP_W-1:0]        op_q;
  logic [TW-1:0]                    now_q;
  logic [ssrl_pkg::REASON_W-1:0]    reason_q;

  ssrl_pkg::svc_state_e             mode_q;
  logic [TW-1:0]                    start_time_q;
  logic [TW-1:0]                    ready_due_q;
  logic [TW-1:0]                    hb_time_q;
  logic [TW-1:0]                    req_start_q;
  logic [TW-1:0]                    restart_due_q;
  logic [TW-1:0]                    hist_q [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0]         hvld_q;
  logic [ssrl_pkg::CNT_W-1:0]       rcnt_q;
  logic                             pend_q;
  logic [TW-1:0]                    hb_age_q;
  ssrl_pkg::err_kind_e              ekind_q;
  logic [ssrl_pkg::REASON_W-1:0]    ereason_q;

  logic                             acc_q;
  logic                             ent_q;
  logic                             hb_ge_q;
  ssrl_pkg::err_kind_e              rkind_q;
  logic [ssrl_pkg::REASON_W-1:0]    rreason_q;

  logic [IDXW-1:0]                  idx_q;
  logic [CNTW-1:0]                  recent_q;
  logic [HISTORY_DEPTH-1:0]         stale_q;
  logic                             free_found_q;
  logic [IDXW-1:0]                  free_idx_q;
  logic [TW-1:0]                    old_age_q;
  logic [IDXW-1:0]                  old_idx_q;

  logic                             out_vld_q;
  ssrl_pkg::svc_state_e             out_state_q;
  logic                             out_acc_q;
  logic                             out_pend_q;
  logic [ssrl_pkg::CNT_W-1:0]       out_rcnt_q;
  logic [ssrl_pkg::AGE_W-1:0]       out_age_q;
  ssrl_pkg::err_kind_e              out_kind_q;
  logic [ssrl_pkg::REASON_W-1:0]    out_reason_q;
  logic                             out_ent_q;

  // Shared unit operands
  logic                             alu_sub;
  logic [TW-1:0]                    alu_b;
  logic [ssrl_pkg::LIM_W-1:0]       alu_lim;
  logic [TW-1:0]                    alu_res;
  ssrl_pkg::alu_flags_t             alu_flags;

  logic                             in_acc;
  logic                             load_out;
  logic                             scan_live;
  logic                             limit_hit;
  logic [IDXW-1:0]                  slot_idx;
  logic [HISTORY_DEPTH-1:0]         slot_mask;
  logic [ssrl_pkg::AGE_W-1:0]       age_sat;

  ssrl_alu #(
    .TIME_WIDTH (TW)
  ) u_alu (
    .sub_i   (alu_sub),
    .a_i     (now_q),
    .b_i     (alu_b),
    .lim_i   (alu_lim),
    .res_o   (alu_res),
    .flags_o (alu_flags)
  );

  always_comb begin
    alu_sub = 1'b1;
    alu_b   = hb_time_q;
    alu_lim = cfg_i.heartbeat_interval;
    case (seq_q)
      SQ_TICK_CHK: begin
        case (mode_q)
          ssrl_pkg::SVC_STARTING: begin
            alu_b   = start_time_q;
            alu_lim = cfg_i.startup_timeout;
          end
          ssrl_pkg::SVC_BUSY: begin
            alu_b   = req_start_q;
            alu_lim = cfg_i.request_timeout;
          end
          default: alu_b = restart_due_q;
        endcase
      end
      SQ_TICK_DUE: alu_b = ready_due_q;
      SQ_SCAN: begin
        alu_b   = hist_q[idx_q];
        alu_lim = cfg_i.restart_window;
      end
      SQ_COMMIT: begin
        alu_sub = 1'b0;
        alu_b   = TW'(cfg_i.restart_cooldown);
      end
      SQ_START: begin
        alu_sub = 1'b0;
        alu_b   = TW'(cfg_i.startup_delay);
      end
      default: ;
    endcase
  end

  assign in_acc    = in_i.valid && in_i.ready;
  assign load_out  = (seq_q == SQ_DONE) && (!out_vld_q || out_o.ready);
  assign scan_live = hvld_q[idx_q];
  assign limit_hit = (CMPW'(recent_q) >= CMPW'(cfg_i.max_restarts));
  assign slot_idx  = free_found_q ? free_idx_q : old_idx_q;
  assign slot_mask = HISTORY_DEPTH'(1) << slot_idx;

  generate
    if (TW > ssrl_pkg::AGE_W) begin : g_age_sat
      always_comb begin
        age_sat = (|hb_age_q[TW-1:ssrl_pkg::AGE_W]) ? '1 : hb_age_q[ssrl_pkg::AGE_W-1:0];
      end
    end else begin : g_age_ext
      always_comb begin
        age_sat = ssrl_pkg::AGE_W'(hb_age_q);
      end
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q         <= SQ_IDLE;
      mode_q        <= ssrl_pkg::SVC_STOPPED;
      start_time_q  <= '0;
      ready_due_q   <= '0;
      hb_time_q     <= '0;
      req_start_q   <= '0;
      restart_due_q <= '0;
      hvld_q        <= '0;
      rcnt_q        <= '0;
      pend_q        <= 1'b0;
      hb_age_q      <= '0;
      ekind_q       <= ssrl_pkg::ERR_NONE;
      ereason_q     <= '0;
      acc_q         <= 1'b0;
      ent_q         <= 1'b0;
      hb_ge_q       <= 1'b0;
      idx_q         <= '0;
      out_vld_q     <= 1'b0;
    end else begin
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end

      case (seq_q)
        SQ_IDLE: begin
          if (in_acc) begin
            acc_q <= 1'b0;
            ent_q <= 1'b0;
            seq_q <= SQ_DISP;
          end
        end

        SQ_DISP: begin
          // Clear scan bookkeeping for a possible restart check
          idx_q        <= '0;
          case (op_q)
            ssrl_pkg::OP_START: seq_q <= SQ_START;
            ssrl_pkg::OP_STOP: begin
              pend_q <= 1'b0;
              mode_q <= ssrl_pkg::SVC_STOPPED;
              ent_q  <= 1'b1;
              seq_q  <= SQ_DONE;
            end
            ssrl_pkg::OP_TICK: begin
              hb_age_q <= alu_res;
              hb_ge_q  <= alu_flags.ge;
              seq_q    <= SQ_TICK_CHK;
            end
            ssrl_pkg::OP_CONFIRM_READY: begin
              if (mode_q == ssrl_pkg::SVC_STARTING) begin
                hb_time_q <= now_q;
                hb_age_q  <= '0;
                mode_q    <= ssrl_pkg::SVC_READY;
                ent_q     <= 1'b1;
              end
              seq_q <= SQ_DONE;
            end
            ssrl_pkg::OP_FAIL_STARTUP: begin
              if (mode_q == ssrl_pkg::SVC_STARTING) begin
                seq_q <= SQ_SCAN;
              end else begin
                seq_q <= SQ_DONE;
              end
            end
            ssrl_pkg::OP_BEGIN_REQUEST: begin
              if (mode_q == ssrl_pkg::SVC_READY) begin
                req_start_q <= now_q;
                pend_q      <= 1'b1;
                hb_time_q   <= now_q;
                hb_age_q    <= '0;
                mode_q      <= ssrl_pkg::SVC_BUSY;
                ent_q       <= 1'b1;
                acc_q       <= 1'b1;
              end
              seq_q <= SQ_DONE;
            end
            ssrl_pkg::OP_COMPLETE_REQUEST: begin
              if (pend_q) begin
                pend_q    <= 1'b0;
                hb_time_q <= now_q;
                hb_age_q  <= '0;
                mode_q    <= ssrl_pkg::SVC_READY;
                ent_q     <= 1'b1;
              end
              seq_q <= SQ_DONE;
            end
            ssrl_pkg::OP_FAIL_REQUEST: seq_q <= SQ_SCAN;
            ssrl_pkg::OP_FORCE_FATAL: begin
              pend_q    <= 1'b0;
              ekind_q   <= ssrl_pkg::ERR_CALLER;
              ereason_q <= reason_q;
              mode_q    <= ssrl_pkg::SVC_FATAL;
              ent_q     <= 1'b1;
              seq_q     <= SQ_DONE;
            end
            default: seq_q <= SQ_DONE;
          endcase
        end

        SQ_TICK_CHK: begin
          case (mode_q)
            ssrl_pkg::SVC_STARTING: begin
              if (alu_flags.gt) begin
                seq_q <= SQ_SCAN;
              end else if (cfg_i.stub_mode) begin
                seq_q <= SQ_TICK_DUE;
              end else begin
                seq_q <= SQ_DONE;
              end
            end
            ssrl_pkg::SVC_BUSY: begin
              if (alu_flags.gt) begin
                seq_q <= SQ_SCAN;
              end else begin
                if (hb_ge_q) begin
                  hb_time_q <= now_q;
                  hb_age_q  <= '0;
                end
                seq_q <= SQ_DONE;
              end
            end
            ssrl_pkg::SVC_RESTARTING: begin
              // Cooldown over: reissue start
              if (!alu_res[TW-1]) begin
                seq_q <= SQ_START;
              end else begin
                seq_q <= SQ_DONE;
              end
            end
            ssrl_pkg::SVC_READY: begin
              if (hb_ge_q) begin
                hb_time_q <= now_q;
                hb_age_q  <= '0;
              end
              seq_q <= SQ_DONE;
            end
            default: seq_q <= SQ_DONE;
          endcase
        end

        SQ_TICK_DUE: begin
          if (!alu_res[TW-1]) begin
            hb_time_q <= now_q;
            hb_age_q  <= '0;
            mode_q    <= ssrl_pkg::SVC_READY;
            ent_q     <= 1'b1;
          end
          seq_q <= SQ_DONE;
        end

        SQ_SCAN: begin
          if (idx_q == LAST_IDX) begin
            seq_q <= SQ_COMMIT;
            idx_q <= '0;
          end else begin
            idx_q <= idx_q + IDXW'(1);
          end
        end

        SQ_COMMIT: begin
          pend_q    <= 1'b0;
          ekind_q   <= rkind_q;
          ereason_q <= rreason_q;
          ent_q     <= 1'b1;
          seq_q     <= SQ_DONE;
          if (limit_hit) begin
            mode_q <= ssrl_pkg::SVC_FATAL;
          end else begin
            hvld_q        <= (hvld_q & ~stale_q) | slot_mask;
            restart_due_q <= alu_res;
            mode_q        <= ssrl_pkg::SVC_RESTARTING;
            if (rcnt_q != '1) begin
              rcnt_q <= rcnt_q + ssrl_pkg::CNT_W'(1);
            end
          end
        end

        SQ_START: begin
          start_time_q <= now_q;
          hb_time_q    <= now_q;
          hb_age_q     <= '0;
          pend_q       <= 1'b0;
          ekind_q      <= ssrl_pkg::ERR_NONE;
          ereason_q    <= '0;
          ready_due_q  <= alu_res;
          mode_q       <= ssrl_pkg::SVC_STARTING;
          ent_q        <= 1'b1;
          seq_q        <= SQ_DONE;
        end

        SQ_DONE: begin
          if (load_out) begin
            seq_q <= SQ_IDLE;
          end
        end

        default: seq_q <= SQ_IDLE;
      endcase
    end
  end

  // Payload: transaction fields, scan bookkeeping, history
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= in_i.op;
      now_q    <= TW'(in_i.now_time);
      reason_q <= in_i.error_reason;
    end

    if (seq_q == SQ_DISP) begin
      recent_q     <= '0;
      stale_q      <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      old_age_q    <= '0;
      old_idx_q    <= '0;
      rkind_q      <= ssrl_pkg::ERR_CALLER;
      rreason_q    <= reason_q;
    end

    if (seq_q == SQ_TICK_CHK) begin
      rkind_q   <= (mode_q == ssrl_pkg::SVC_BUSY) ? ssrl_pkg::ERR_REQ_TMO
                                                  : ssrl_pkg::ERR_START_TMO;
      rreason_q <= '0;
    end

    if (seq_q == SQ_SCAN) begin
      if (scan_live && !alu_flags.gt) begin
        recent_q <= recent_q + CNTW'(1);
      end
      if (scan_live && alu_flags.gt) begin
        stale_q[idx_q] <= 1'b1;
      end
      // First slot that is free once stale entries are dropped
      if (!free_found_q && (!scan_live || alu_flags.gt)) begin
        free_found_q <= 1'b1;
        free_idx_q   <= idx_q;
      end
      if (alu_res > old_age_q) begin
        old_age_q <= alu_res;
        old_idx_q <= idx_q;
      end
    end

    if ((seq_q == SQ_COMMIT) && !limit_hit) begin
      hist_q[slot_idx] <= now_q;
    end

    if (load_out) begin
      out_state_q  <= mode_q;
      out_acc_q    <= acc_q;
      out_pend_q   <= pend_q;
      out_rcnt_q   <= rcnt_q;
      out_age_q    <= age_sat;
      out_kind_q   <= ekind_q;
      out_reason_q <= ereason_q;
      out_ent_q    <= ent_q;
    end
  end

  assign in_i.ready             = (seq_q == SQ_IDLE);
  assign out_o.valid            = out_vld_q;
  assign out_o.service_state    = out_state_q;
  assign out_o.request_accepted = out_acc_q;
  assign out_o.pending_request  = out_pend_q;
  assign out_o.restart_total    = out_rcnt_q;
  assign out_o.heartbeat_age    = out_age_q;
  assign out_o.error_kind       = out_kind_q;
  assign out_o.last_reason      = out_reason_q;
  assign out_o.state_changed    = out_ent_q;

  a_pend_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> mode_q == ssrl_pkg::SVC_BUSY)
    else $error("pending request outside busy state");

  a_commit_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q == SQ_COMMIT |-> $past(seq_q) == SQ_SCAN && $past(idx_q) == LAST_IDX)
    else $error("restart decision without full history walk");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_acc_q |-> out_state_q == ssrl_pkg::SVC_BUSY && out_pend_q && out_ent_q)
    else $error("accepted request not reported busy and pending");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> rcnt_q >= $past(rcnt_q))
    else $error("restart count decreased");

endmodule

// ===== hw/rtl/service_supervisor_restart_limiter_core.sv =====
// Each event passes a dispatch state and then a done state that loads the result into the
// output register; tick and start pass through extra states, and a restart first walks the
// history one slot a cycle. One event at a time: the input is ready again once the result is
// in the output register; a result still waiting there holds the next event in its done state.
// Reset (async, active low): service stopped, counters, times and history valid bits
// cleared, configuration at defaults; history entries themselves are not cleared.
module service_supervisor_restart_limiter_core #(
  parameter int unsigned HISTORY_DEPTH = 8,
  parameter int unsigned TIME_WIDTH    = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ssrl_in_if.sink                       in_i,
  ssrl_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssrl_pkg::ADDR_W-1:0]   paddr,
  input  logic [ssrl_pkg::DATA_W-1:0]   pwdata,
  output logic [ssrl_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  ssrl_pkg::cfg_t      cfg_q;
  ssrl_pkg::reg_idx_e  reg_idx;
  logic                wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = ssrl_pkg::reg_idx_e'(paddr[ssrl_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.startup_delay      <= ssrl_pkg::RST_STARTUP_DELAY;
      cfg_q.startup_timeout    <= ssrl_pkg::RST_STARTUP_TIMEOUT;
      cfg_q.request_timeout    <= ssrl_pkg::RST_REQUEST_TIMEOUT;
      cfg_q.heartbeat_interval <= ssrl_pkg::RST_HEARTBEAT_INTVL;
      cfg_q.restart_window     <= ssrl_pkg::RST_RESTART_WINDOW;
      cfg_q.max_restarts       <= ssrl_pkg::RST_MAX_RESTARTS;
      cfg_q.restart_cooldown   <= ssrl_pkg::RST_RESTART_COOLDOWN;
      cfg_q.stub_mode          <= ssrl_pkg::RST_STUB_MODE;
    end else if (wr_en) begin
      case (reg_idx)
        ssrl_pkg::REG_STARTUP_DELAY:    cfg_q.startup_delay <= pwdata[ssrl_pkg::LIM_W-1:0];
        ssrl_pkg::REG_STARTUP_TIMEOUT:  cfg_q.startup_timeout <= pwdata[ssrl_pkg::LIM_W-1:0];
        ssrl_pkg::REG_REQUEST_TIMEOUT:  cfg_q.request_timeout <= pwdata[ssrl_pkg::LIM_W-1:0];
        ssrl_pkg::REG_HEARTBEAT_INTVL:
          cfg_q.heartbeat_interval <= pwdata[ssrl_pkg::LIM_W-1:0];
        ssrl_pkg::REG_RESTART_WINDOW:   cfg_q.restart_window <= pwdata[ssrl_pkg::LIM_W-1:0];
        ssrl_pkg::REG_MAX_RESTARTS:     cfg_q.max_restarts <= pwdata[ssrl_pkg::MAXR_W-1:0];
        ssrl_pkg::REG_RESTART_COOLDOWN:
          cfg_q.restart_cooldown <= pwdata[ssrl_pkg::LIM_W-1:0];
        ssrl_pkg::REG_STUB_MODE:        cfg_q.stub_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ssrl_pkg::REG_STARTUP_DELAY:    prdata = ssrl_pkg::DATA_W'(cfg_q.startup_delay);
      ssrl_pkg::REG_STARTUP_TIMEOUT:  prdata = ssrl_pkg::DATA_W'(cfg_q.startup_timeout);
      ssrl_pkg::REG_REQUEST_TIMEOUT:  prdata = ssrl_pkg::DATA_W'(cfg_q.request_timeout);
      ssrl_pkg::REG_HEARTBEAT_INTVL:  prdata = ssrl_pkg::DATA_W'(cfg_q.heartbeat_interval);
      ssrl_pkg::REG_RESTART_WINDOW:   prdata = ssrl_pkg::DATA_W'(cfg_q.restart_window);
      ssrl_pkg::REG_MAX_RESTARTS:     prdata = ssrl_pkg::DATA_W'(cfg_q.max_restarts);
      ssrl_pkg::REG_RESTART_COOLDOWN: prdata = ssrl_pkg::DATA_W'(cfg_q.restart_cooldown);
      ssrl_pkg::REG_STUB_MODE:        prdata = ssrl_pkg::DATA_W'(cfg_q.stub_mode);
      default:                        prdata = '0;
    endcase
  end

  ssrl_ctrl #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TIME_WIDTH    (TIME_WIDTH)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

// ===== tb/service_supervisor_restart_limiter_core_test.sv =====
module service_supervisor_restart_limiter_core_test;
  import ssrl_pkg::*;

  localparam int unsigned LOG_DEPTH     = 8;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned PHASE_ITEMS   = 135;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned RUN_LIMIT     = 4000000;
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd9;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

  typedef struct packed {
    svc_state_e          state;
    logic                accepted;
    logic                pending;
    logic [CNT_W-1:0]    total;
    logic [AGE_W-1:0]    age;
    err_kind_e           kind;
    logic [REASON_W-1:0] why;
    logic                changed;
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [NOW_W-1:0]    now;
    logic [REASON_W-1:0] why;
    logic                fixed;
    status_t             want;
  } probe_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  ssrl_in_if  in_if ();
  ssrl_out_if out_if ();

  service_supervisor_restart_limiter_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Supervisor state as the block should hold it
  cfg_t                lim;
  svc_state_e          svc_mode;
  logic [NOW_W-1:0]    t_start;
  logic [NOW_W-1:0]    t_ready_due;
  logic [NOW_W-1:0]    t_heartbeat;
  logic [NOW_W-1:0]    t_request;
  logic [NOW_W-1:0]    t_restart_due;
  logic [NOW_W-1:0]    restart_log [LOG_DEPTH];
  logic [LOG_DEPTH-1:0] restart_log_v;
  logic [CNT_W-1:0]    restarts_seen;
  logic                req_open;
  logic [AGE_W-1:0]    hb_age;
  err_kind_e           last_kind;
  logic [REASON_W-1:0] last_why;
  logic                mode_entered;

  status_t             status_q [$];
  int unsigned         mismatches;
  logic                calm;

  function automatic void enter_state(svc_state_e s);
    svc_mode = s;
    mode_entered = 1'b1;
  endfunction

  function automatic void beat(logic [NOW_W-1:0] now);
    t_heartbeat = now;
    hb_age = '0;
  endfunction

  function automatic logic reached(logic [NOW_W-1:0] now, logic [NOW_W-1:0] due);
    logic [NOW_W-1:0] d;
    d = now - due;
    return !d[NOW_W-1];
  endfunction

  function automatic void launch(logic [NOW_W-1:0] now);
    t_start = now;
    beat(now);
    req_open = 1'b0;
    last_kind = ERR_NONE;
    last_why = '0;
    t_ready_due = now + NOW_W'(lim.startup_delay);
    enter_state(SVC_STARTING);
  endfunction

  function automatic void halt_fatal(err_kind_e kind, logic [REASON_W-1:0] why);
    req_open = 1'b0;
    last_kind = kind;
    last_why = why;
    enter_state(SVC_FATAL);
  endfunction

  function automatic void schedule_restart(logic [NOW_W-1:0] now, err_kind_e kind,
                                           logic [REASON_W-1:0] why);
    logic [NOW_W-1:0] age;
    logic [NOW_W-1:0] oldest;
    int recent;
    int slot;
    int i;
    recent = 0;
    slot = -1;
    oldest = '0;
    for (i = 0; i < LOG_DEPTH; i++) begin
      age = now - restart_log[i];
      if (restart_log_v[i] && age <= NOW_W'(lim.restart_window)) recent++;
    end
    if (recent >= int'(lim.max_restarts)) begin
      halt_fatal(kind, why);
      return;
    end
    // drop entries that fell out of the window, then take the first free slot
    for (i = 0; i < LOG_DEPTH; i++) begin
      age = now - restart_log[i];
      if (restart_log_v[i] && age > NOW_W'(lim.restart_window)) restart_log_v[i] = 1'b0;
    end
    for (i = 0; i < LOG_DEPTH; i++) begin
      if (slot < 0 && !restart_log_v[i]) slot = i;
    end
    if (slot < 0) begin
      slot = 0;
      for (i = 0; i < LOG_DEPTH; i++) begin
        age = now - restart_log[i];
        if (age > oldest) begin
          oldest = age;
          slot = i;
        end
      end
    end
    restart_log[slot] = now;
    restart_log_v[slot] = 1'b1;
    if (restarts_seen != '1) restarts_seen++;
    last_kind = kind;
    last_why = why;
    req_open = 1'b0;
    t_restart_due = now + NOW_W'(lim.restart_cooldown);
    enter_state(SVC_RESTARTING);
  endfunction

  function automatic status_t supervise(logic [OP_W-1:0] op, logic [NOW_W-1:0] now,
                                        logic [REASON_W-1:0] why);
    status_t r;
    logic took;
    logic acted;
    took = 1'b0;
    acted = 1'b0;
    mode_entered = 1'b0;
    case (op)
      OP_START: launch(now);
      OP_STOP: begin
        req_open = 1'b0;
        enter_state(SVC_STOPPED);
      end
      OP_TICK: begin
        hb_age = now - t_heartbeat;
        case (svc_mode)
          SVC_STARTING: begin
            if (NOW_W'(now - t_start) > NOW_W'(lim.startup_timeout)) begin
              schedule_restart(now, ERR_START_TMO, '0);
              acted = 1'b1;
            end else if (lim.stub_mode && reached(now, t_ready_due)) begin
              beat(now);
              enter_state(SVC_READY);
              acted = 1'b1;
            end
          end
          SVC_BUSY: begin
            if (NOW_W'(now - t_request) > NOW_W'(lim.request_timeout)) begin
              schedule_restart(now, ERR_REQ_TMO, '0);
              acted = 1'b1;
            end
          end
          SVC_RESTARTING: begin
            if (reached(now, t_restart_due)) begin
              launch(now);
              acted = 1'b1;
            end
          end
          default: ;
        endcase
        if (!acted && (svc_mode == SVC_READY || svc_mode == SVC_BUSY) &&
            hb_age >= AGE_W'(lim.heartbeat_interval)) beat(now);
      end
      OP_CONFIRM_READY: begin
        if (svc_mode == SVC_STARTING) begin
          beat(now);
          enter_state(SVC_READY);
        end
      end
      OP_FAIL_STARTUP: begin
        if (svc_mode == SVC_STARTING) schedule_restart(now, ERR_CALLER, why);
      end
      OP_BEGIN_REQUEST: begin
        if (svc_mode == SVC_READY) begin
          t_request = now;
          req_open = 1'b1;
          beat(now);
          enter_state(SVC_BUSY);
          took = 1'b1;
        end
      end
      OP_COMPLETE_REQUEST: begin
        if (req_open) begin
          req_open = 1'b0;
          beat(now);
          enter_state(SVC_READY);
        end
      end
      OP_FAIL_REQUEST: schedule_restart(now, ERR_CALLER, why);
      OP_FORCE_FATAL: halt_fatal(ERR_CALLER, why);
      default: ;
    endcase
    r.state = svc_mode;
    r.accepted = took;
    r.pending = req_open;
    r.total = restarts_seen;
    r.age = hb_age;
    r.kind = last_kind;
    r.why = last_why;
    r.changed = mode_entered;
    return r;
  endfunction

  // Steer random traffic toward operations that move the current state forward
  function automatic logic [OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    case (svc_mode)
      SVC_STARTING:   return r < 40 ? OP_CONFIRM_READY : (r < 85 ? OP_TICK : OP_FAIL_STARTUP);
      SVC_READY:      return r < 50 ? OP_BEGIN_REQUEST : (r < 95 ? OP_TICK : OP_STOP);
      SVC_BUSY:       return r < 40 ? OP_COMPLETE_REQUEST : (r < 85 ? OP_TICK : OP_FAIL_REQUEST);
      SVC_RESTARTING: return r < 90 ? OP_TICK : OP_START;
      default:        return r < 85 ? OP_START : OP_TICK;
    endcase
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] w, logic [31:0] g);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t mismatch %s: expected 0x%0h, got 0x%0h", $time, what, w, g);
  endfunction

  task automatic check_status();
    status_t got;
    status_t want;
    got.state = svc_state_e'(out_if.service_state);
    got.accepted = out_if.request_accepted;
    got.pending = out_if.pending_request;
    got.total = out_if.restart_total;
    got.age = out_if.heartbeat_age;
    got.kind = err_kind_e'(out_if.error_kind);
    got.why = out_if.last_reason;
    got.changed = out_if.state_changed;
    if (status_q.size() == 0) begin
      note_mismatch("unexpected result, service_state", '0, got.state);
    end else begin
      want = status_q.pop_front();
      if (got.state !== want.state) note_mismatch("service_state", want.state, got.state);
      if (got.accepted !== want.accepted)
        note_mismatch("request_accepted", want.accepted, got.accepted);
      if (got.pending !== want.pending)
        note_mismatch("pending_request", want.pending, got.pending);
      if (got.total !== want.total) note_mismatch("restart_total", want.total, got.total);
      if (got.age !== want.age) note_mismatch("heartbeat_age", want.age, got.age);
      if (got.kind !== want.kind) note_mismatch("error_kind", want.kind, got.kind);
      if (got.why !== want.why) note_mismatch("last_reason", want.why, got.why);
      if (got.changed !== want.changed)
        note_mismatch("state_changed", want.changed, got.changed);
    end
  endtask

  task automatic write_reg(reg_idx_e idx, logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_STARTUP_DELAY:    lim.startup_delay = value[LIM_W-1:0];
      REG_STARTUP_TIMEOUT:  lim.startup_timeout = value[LIM_W-1:0];
      REG_REQUEST_TIMEOUT:  lim.request_timeout = value[LIM_W-1:0];
      REG_HEARTBEAT_INTVL:  lim.heartbeat_interval = value[LIM_W-1:0];
      REG_RESTART_WINDOW:   lim.restart_window = value[LIM_W-1:0];
      REG_MAX_RESTARTS:     lim.max_restarts = value[MAXR_W-1:0];
      REG_RESTART_COOLDOWN: lim.restart_cooldown = value[LIM_W-1:0];
      REG_STUB_MODE:        lim.stub_mode = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [LIM_W-1:0] dly, logic [LIM_W-1:0] st_tmo,
                                logic [LIM_W-1:0] rq_tmo, logic [LIM_W-1:0] hb,
                                logic [LIM_W-1:0] win, logic [MAXR_W-1:0] maxr,
                                logic [LIM_W-1:0] cool, logic stub);
    write_reg(REG_STARTUP_DELAY, DATA_W'(dly));
    write_reg(REG_STARTUP_TIMEOUT, DATA_W'(st_tmo));
    write_reg(REG_REQUEST_TIMEOUT, DATA_W'(rq_tmo));
    write_reg(REG_HEARTBEAT_INTVL, DATA_W'(hb));
    write_reg(REG_RESTART_WINDOW, DATA_W'(win));
    write_reg(REG_MAX_RESTARTS, DATA_W'(maxr));
    write_reg(REG_RESTART_COOLDOWN, DATA_W'(cool));
    write_reg(REG_STUB_MODE, DATA_W'(stub));
  endtask

  task automatic send_event(logic [OP_W-1:0] op, logic [NOW_W-1:0] now,
                            logic [REASON_W-1:0] why, logic fixed, status_t want);
    status_t predicted;
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.now_time <= now;
    in_if.error_reason <= why;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = supervise(op, now, why);
    status_q.push_back(fixed ? want : predicted);
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic settle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned step_max);
    logic [NOW_W-1:0] clock_t;
    logic [NOW_W-1:0] now;
    logic [OP_W-1:0]  op;
    int unsigned      roll;
    clock_t = $urandom;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) == 0) settle();
      clock_t += $urandom_range(0, step_max);
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        op = OP_W'($urandom_range(0, 15));
        now = roll < 4 ? $urandom : clock_t;
      end else begin
        op = pick_op();
        now = clock_t;
      end
      send_event(op, now, REASON_W'($urandom_range(0, 255)), 1'b0, '0);
    end
    settle();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned stall;
    stall = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        check_status();
        stall = calm ? 0 : $urandom_range(0, 7);
      end
      @(negedge clk_i);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    probe_t plan [25];
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.op = '0;
    in_if.now_time = '0;
    in_if.error_reason = '0;
    calm = 1'b0;
    mismatches = 0;

    lim = '{startup_delay: RST_STARTUP_DELAY, startup_timeout: RST_STARTUP_TIMEOUT,
            request_timeout: RST_REQUEST_TIMEOUT, heartbeat_interval: RST_HEARTBEAT_INTVL,
            restart_window: RST_RESTART_WINDOW, max_restarts: RST_MAX_RESTARTS,
            restart_cooldown: RST_RESTART_COOLDOWN, stub_mode: RST_STUB_MODE};
    svc_mode = SVC_STOPPED;
    t_start = '0;
    t_ready_due = '0;
    t_heartbeat = '0;
    t_request = '0;
    t_restart_due = '0;
    foreach (restart_log[i]) restart_log[i] = '0;
    restart_log_v = '0;
    restarts_seen = '0;
    req_open = 1'b0;
    hb_age = '0;
    last_kind = ERR_NONE;
    last_why = '0;
    mode_entered = 1'b0;

    // Walk the default configuration through every state, the ignored cases and a wrap
    plan = '{
      '{OP_UNUSED_LO, 32'd0, 8'h00, 1'b1,
        '{SVC_STOPPED, 1'b0, 1'b0, 32'd0, 32'd0, ERR_NONE, 8'h00, 1'b0}},
      '{OP_UNUSED_HI, 32'hFFFF_FFFF, 8'hFF, 1'b1,
        '{SVC_STOPPED, 1'b0, 1'b0, 32'd0, 32'd0, ERR_NONE, 8'h00, 1'b0}},
      '{OP_TICK, 32'd5, 8'h00, 1'b1,
        '{SVC_STOPPED, 1'b0, 1'b0, 32'd0, 32'd5, ERR_NONE, 8'h00, 1'b0}},
      '{OP_CONFIRM_READY, 32'd6, 8'h00, 1'b1,
        '{SVC_STOPPED, 1'b0, 1'b0, 32'd0, 32'd5, ERR_NONE, 8'h00, 1'b0}},
      '{OP_FAIL_REQUEST, 32'd100, 8'hFF, 1'b1,
        '{SVC_RESTARTING, 1'b0, 1'b0, 32'd1, 32'd5, ERR_CALLER, 8'hFF, 1'b1}},
      '{OP_FORCE_FATAL, 32'd200, 8'hA5, 1'b0, '0},
      '{OP_START, 32'd1000, 8'h00, 1'b0, '0},
      '{OP_COMPLETE_REQUEST, 32'd1001, 8'h00, 1'b0, '0},
      '{OP_BEGIN_REQUEST, 32'd1002, 8'h00, 1'b0, '0},
      '{OP_FAIL_STARTUP, 32'd1100, 8'h5A, 1'b0, '0},
      '{OP_TICK, 32'd3100, 8'h00, 1'b0, '0},
      '{OP_TICK, 32'd13100, 8'h00, 1'b0, '0},
      '{OP_TICK, 32'd13101, 8'h00, 1'b0, '0},
      '{OP_START, 32'd14000, 8'h00, 1'b0, '0},
      '{OP_CONFIRM_READY, 32'd14010, 8'h00, 1'b0, '0},
      '{OP_TICK, 32'd14500, 8'h00, 1'b0, '0},
      '{OP_TICK, 32'd15010, 8'h00, 1'b0, '0},
      '{OP_BEGIN_REQUEST, 32'd15020, 8'h00, 1'b0, '0},
      '{OP_BEGIN_REQUEST, 32'd15030, 8'h00, 1'b0, '0},
      '{OP_COMPLETE_REQUEST, 32'd15100, 8'h00, 1'b0, '0},
      '{OP_BEGIN_REQUEST, 32'd15200, 8'h00, 1'b0, '0},
      '{OP_TICK, 32'd45201, 8'h00, 1'b0, '0},
      '{OP_FAIL_REQUEST, 32'hFFFF_FFF0, 8'h3C, 1'b0, '0},
      '{OP_FORCE_FATAL, 32'd0, 8'h00, 1'b0, '0},
      '{OP_STOP, 32'd1, 8'h00, 1'b0, '0}
    };

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[k]) send_event(plan[k].op, plan[k].now, plan[k].why, plan[k].fixed,
                                 plan[k].want);
    settle();

    // Short limits so timeouts, cooldowns and the restart limit all fire
    apply_settings(24'd5, 24'd40, 24'd60, 24'd10, 24'd200, 4'd3, 24'd20, 1'b0);
    run_phase(15);
    // Zero everywhere: every failure goes fatal, stub startup is immediate
    apply_settings(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 4'd0, 24'd0, 1'b1);
    run_phase(3);
    // Limit above the history depth: fill the history and overwrite the oldest
    apply_settings(24'd8, 24'd30, 24'd50, 24'd7, 24'hFF_FFFF, 4'd15, 24'd10, 1'b0);
    run_phase(12);
    // Maximum time limits and a restart limit of 8, with large time steps to still reach them
    apply_settings(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 4'd8,
                   24'hFF_FFFF, 1'b1);
    run_phase(32'h0040_0000);
    apply_settings(LIM_W'($urandom_range(0, 30)), LIM_W'($urandom_range(0, 80)),
                   LIM_W'($urandom_range(0, 80)), LIM_W'($urandom_range(0, 20)),
                   LIM_W'($urandom_range(0, 400)), MAXR_W'($urandom_range(0, 8)),
                   LIM_W'($urandom_range(0, 40)), 1'($urandom_range(0, 1)));
    run_phase(20);

    if (mismatches == 0 && status_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
